// ----- rtl/satq_pkg.sv -----
// shared types, codes and defaults for the sorted alarm timer queue
`default_nettype none

package satq_pkg;

    // default sizes
    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_ID_BITS     = 16;
    localparam int DEF_TIME_BITS   = 32;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_POP    = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    // request beat
    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] object_id;
        logic [31:0] fire_time;
        logic [31:0] current_time;
    } satq_req_t;

    // response beat
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] fired_id;
    } satq_rsp_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RIPPLE,
        S_PLACE,
        S_EMIT
    } satq_state_t;

    // controls broadcast to every cell
    typedef struct packed {
        logic scan_id;
        logic scan_pop;
        logic ripple;
        logic place;
    } satq_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/sorted_alarm_timer_queue.sv -----
// Sorted alarm timer queue: top level with the chain of slot cells.
// Sequence: scan; on an id hit or an expired head on pop, the hole then ripples
// through the cells to the tail; an insert then places its entry; last an emit.
// Flow: one operation at a time; the next request is not taken before the last
// one leaves emit. A new request is taken while a response waits.
// Reset: fill count cleared, queue empty; slot contents are not cleared.
`default_nettype none

module sorted_alarm_timer_queue
    import satq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS,
    parameter int TIME_BITS   = DEF_TIME_BITS
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    input  wire satq_req_t req,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output satq_rsp_t      rsp
);

    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    satq_ctl_t            ctl;
    logic [CNT_BITS-1:0]  count;
    logic [ID_BITS-1:0]   op_id;
    logic [TIME_BITS-1:0] op_time;
    logic [TIME_BITS-1:0] now;

    logic [ID_BITS-1:0]   ids   [QUEUE_DEPTH];
    logic [TIME_BITS-1:0] times [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] flags;
    logic [QUEUE_DEPTH-1:0] holes;
    logic [QUEUE_DEPTH-1:0] hit_bits;

    // sequencer
    satq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS),
        .TIME_BITS   (TIME_BITS),
        .CNT_BITS    (CNT_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .any_match (|hit_bits),
        .any_hole  (|holes),
        .head_id   (ids[0]),
        .ctl       (ctl),
        .count     (count),
        .op_id     (op_id),
        .op_time   (op_time),
        .now       (now)
    );

    // chain of cells, head at index zero
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic [ID_BITS-1:0]   prev_id;
        logic [TIME_BITS-1:0] prev_time;
        logic                 prev_flag;
        logic                 prev_hole;
        logic [ID_BITS-1:0]   next_id;
        logic [TIME_BITS-1:0] next_time;

        if (i == 0)
        begin : g_head
            assign prev_id   = '0;
            assign prev_time = '0;
            assign prev_flag = 1'b0;
            assign prev_hole = 1'b0;
        end
        else
        begin : g_mid
            assign prev_id   = ids[i-1];
            assign prev_time = times[i-1];
            assign prev_flag = flags[i-1];
            assign prev_hole = holes[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign next_id   = '0;
            assign next_time = '0;
        end
        else
        begin : g_body
            assign next_id   = ids[i+1];
            assign next_time = times[i+1];
        end

        satq_cell #(
            .INDEX       (i),
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .ID_BITS     (ID_BITS),
            .TIME_BITS   (TIME_BITS),
            .CNT_BITS    (CNT_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .count     (count),
            .op_id     (op_id),
            .op_time   (op_time),
            .now       (now),
            .prev_id   (prev_id),
            .prev_time (prev_time),
            .prev_flag (prev_flag),
            .prev_hole (prev_hole),
            .next_id   (next_id),
            .next_time (next_time),
            .ent_id    (ids[i]),
            .ent_time  (times[i]),
            .flag      (flags[i]),
            .hole      (holes[i]),
            .match     (hit_bits[i])
        );
    end

endmodule

`default_nettype wire

// ----- rtl/satq_cell.sv -----
// one queue slot: holds an alarm and trades it with its neighbors
`default_nettype none

module satq_cell
    import satq_pkg::*;
#(
    parameter int INDEX       = 0,
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS,
    parameter int TIME_BITS   = DEF_TIME_BITS,
    parameter int CNT_BITS    = $clog2(QUEUE_DEPTH + 1)
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire satq_ctl_t            ctl,
    input  wire logic [CNT_BITS-1:0]  count,
    input  wire logic [ID_BITS-1:0]   op_id,
    input  wire logic [TIME_BITS-1:0] op_time,
    input  wire logic [TIME_BITS-1:0] now,
    input  wire logic [ID_BITS-1:0]   prev_id,
    input  wire logic [TIME_BITS-1:0] prev_time,
    input  wire logic                 prev_flag,
    input  wire logic                 prev_hole,
    input  wire logic [ID_BITS-1:0]   next_id,
    input  wire logic [TIME_BITS-1:0] next_time,
    output logic [ID_BITS-1:0]        ent_id,
    output logic [TIME_BITS-1:0]      ent_time,
    output logic                      flag,
    output logic                      hole,
    output logic                      match
);

    localparam logic                IS_HEAD  = (INDEX == 0);
    localparam logic [CNT_BITS-1:0] MY_POS   = CNT_BITS'(INDEX);
    localparam logic [CNT_BITS-1:0] NEXT_POS = CNT_BITS'(INDEX + 1);

    logic [ID_BITS-1:0]   id_reg,   id_next;
    logic [TIME_BITS-1:0] time_reg, time_next;
    logic                 hole_reg, hole_next;
    logic                 valid;
    logic                 next_valid;

    // occupancy from the fill count
    assign valid      = (MY_POS < count);
    assign next_valid = (NEXT_POS < count);

    // insert point marker: empty slot or later fire time
    assign flag = !valid || (time_reg > op_time);

    // id hit, or expired head on pop
    always_comb
    begin
        match = 1'b0;
        if (ctl.scan_id)
        begin
            match = valid && (id_reg == op_id);
        end
        else if (ctl.scan_pop)
        begin
            match = IS_HEAD && valid && (time_reg < now);
        end
    end

    // hole marker: set by a scan hit, then moves one slot toward the tail per cycle while rippling
    always_comb
    begin
        hole_next = hole_reg;
        if (ctl.scan_id || ctl.scan_pop)
        begin
            hole_next = match;
        end
        else if (ctl.ripple)
        begin
            hole_next = prev_hole && valid;
        end
    end

    // entry data: pull from tail side on ripple, push toward tail on place
    always_comb
    begin
        id_next   = id_reg;
        time_next = time_reg;
        if (ctl.ripple && hole_reg && next_valid)
        begin
            id_next   = next_id;
            time_next = next_time;
        end
        else if (ctl.place && flag)
        begin
            if (prev_flag)
            begin
                id_next   = prev_id;
                time_next = prev_time;
            end
            else
            begin
                id_next   = op_id;
                time_next = op_time;
            end
        end
    end

    // hole register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hole_reg <= 1'b0;
        end
        else
        begin
            hole_reg <= hole_next;
        end
    end

    // entry payload
    always_ff @(posedge clk)
    begin
        id_reg   <= id_next;
        time_reg <= time_next;
    end

    assign ent_id   = id_reg;
    assign ent_time = time_reg;
    assign hole     = hole_reg;

endmodule

`default_nettype wire

// ----- rtl/satq_ctrl.sv -----
// sequencer, fill count and response register for the alarm queue
`default_nettype none

module satq_ctrl
    import satq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS,
    parameter int TIME_BITS   = DEF_TIME_BITS,
    parameter int CNT_BITS    = $clog2(QUEUE_DEPTH + 1)
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire satq_req_t            req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output satq_rsp_t                 rsp,
    input  wire logic                 any_match,
    input  wire logic                 any_hole,
    input  wire logic [ID_BITS-1:0]   head_id,
    output satq_ctl_t                 ctl,
    output logic [CNT_BITS-1:0]       count,
    output logic [ID_BITS-1:0]        op_id,
    output logic [TIME_BITS-1:0]      op_time,
    output logic [TIME_BITS-1:0]      now
);

    localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(QUEUE_DEPTH);
    localparam logic [CNT_BITS-1:0] ONE        = CNT_BITS'(1);

    satq_state_t          state_reg, state_next;
    logic [1:0]           op_reg,    op_next;
    logic [ID_BITS-1:0]   id_reg,    id_next;
    logic [TIME_BITS-1:0] ft_reg,    ft_next;
    logic [TIME_BITS-1:0] now_reg,   now_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [1:0]           status_reg, status_next;
    logic [15:0]          fired_reg,  fired_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    satq_rsp_t            rsp_reg,   rsp_next;
    logic                 is_insert;
    logic                 is_known;
    logic                 rsp_free;

    assign is_insert = (op_reg == OP_INSERT);
    assign is_known  = (op_reg == OP_INSERT) || (op_reg == OP_REMOVE) || (op_reg == OP_POP);
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!is_known)
                begin
                    state_next = S_EMIT;
                end
                else if (any_match)
                begin
                    state_next = S_RIPPLE;
                end
                else if (is_insert)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_RIPPLE:
            begin
                if (!any_hole)
                begin
                    state_next = is_insert ? S_PLACE : S_EMIT;
                end
            end
            S_PLACE:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // operation, count and response data
    always_comb
    begin
        op_next        = op_reg;
        id_next        = id_reg;
        ft_next        = ft_reg;
        now_next       = now_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        fired_next     = fired_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next  = req.operation;
                    id_next  = ID_BITS'(req.object_id);
                    ft_next  = TIME_BITS'(req.fire_time);
                    now_next = TIME_BITS'(req.current_time);
                end
            end
            S_SCAN:
            begin
                status_next = ST_NONE;
                fired_next  = 16'd0;
                if ((op_reg == OP_POP) && any_match)
                begin
                    fired_next = 16'(head_id);
                end
            end
            S_RIPPLE:
            begin
                if (!any_hole)
                begin
                    count_next  = count_reg - ONE;
                    status_next = ST_DONE;
                end
            end
            S_PLACE:
            begin
                if (count_reg == FULL_COUNT)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_DONE;
                    count_next  = count_reg + ONE;
                end
            end
            S_EMIT:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_next.status   = status_reg;
                    rsp_next.fired_id = fired_reg;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready    = (state_reg == S_IDLE);
        ctl.scan_id  = (state_reg == S_SCAN) &&
                       ((op_reg == OP_INSERT) || (op_reg == OP_REMOVE));
        ctl.scan_pop = (state_reg == S_SCAN) && (op_reg == OP_POP);
        ctl.ripple   = (state_reg == S_RIPPLE);
        ctl.place    = (state_reg == S_PLACE) && (count_reg != FULL_COUNT);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        id_reg     <= id_next;
        ft_reg     <= ft_next;
        now_reg    <= now_next;
        status_reg <= status_next;
        fired_reg  <= fired_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign count     = count_reg;
    assign op_id     = id_reg;
    assign op_time   = ft_reg;
    assign now       = now_reg;

endmodule

`default_nettype wire
